// File: sv/bvs_pkg.sv
// ----------------------------------------------------------------------------
// Bit-vector select package
// Shared types, codes and defaults for the bit-vector select block.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int unsigned MAX_BITS_DEFAULT = 4096;
  localparam int unsigned POS_W            = 13;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_SELECT = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_SEARCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic             bit_value;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] occurrence;
  } in_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_req_t;

endpackage

// File: sv/bvs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module bvs_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bvs_engine.sv
// ----------------------------------------------------------------------------
// Bit-vector select engine
// Keeps the loaded length, appends prefix counts of ones to the RAM and runs
// the base read and binary search of a select request, one RAM read a step.
// ----------------------------------------------------------------------------
module bvs_engine #(
  parameter int unsigned MAX_BITS = bvs_pkg::MAX_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bvs_pkg::in_req_t            in_req_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output bvs_pkg::out_req_t           res_o,
  output logic                        mem_we_o,
  output logic [$clog2(MAX_BITS)-1:0] mem_addr_o,
  output logic [$clog2(MAX_BITS+1)-1:0] mem_wdata_o,
  input  logic [$clog2(MAX_BITS+1)-1:0] mem_rdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_BITS);
  localparam int unsigned LEN_W = $clog2(MAX_BITS + 1);
  localparam int unsigned TGT_W = ((LEN_W > bvs_pkg::POS_W) ? LEN_W : bvs_pkg::POS_W) + 1;

  bvs_pkg::state_e   state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  ones_q, ones_d;
  logic [LEN_W-1:0]  lo_q, lo_d;
  logic [LEN_W-1:0]  hi_q, hi_d;
  logic [IDX_W-1:0]  mid_q, mid_d;
  logic [TGT_W-1:0]  target_q, target_d;
  logic              bit_q, bit_d;
  bvs_pkg::out_req_t res_q, res_d;

  logic [LEN_W-1:0]  count_val;
  logic              below;
  logic [LEN_W-1:0]  lo_n, hi_n;
  logic [LEN_W:0]    mid_sum;
  logic [LEN_W:0]    pos_sum;
  logic [TGT_W-1:0]  start_idx;
  logic [LEN_W-1:0]  add_bit;

  // The RAM holds ones counts; the zeros count of an entry is its length minus that.
  assign count_val = bit_q ? mem_rdata_i : (LEN_W'(mid_q) + LEN_W'(1) - mem_rdata_i);
  assign below     = TGT_W'(count_val) < target_q;
  assign lo_n      = below ? (LEN_W'(mid_q) + LEN_W'(1)) : lo_q;
  assign hi_n      = below ? hi_q : LEN_W'(mid_q);
  assign mid_sum   = ((LEN_W + 1)'(lo_n) + (LEN_W + 1)'(hi_n)) >> 1;
  assign pos_sum   = (LEN_W + 1)'(lo_n) + (LEN_W + 1)'(1);
  assign start_idx = TGT_W'(in_req_i.start_pos) - TGT_W'(2);
  assign add_bit   = LEN_W'(in_req_i.bit_value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bvs_pkg::ST_IDLE;
      len_q   <= '0;
      ones_q  <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ones_q  <= ones_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    target_q <= target_d;
    bit_q    <= bit_d;
    res_q    <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ones_d      = ones_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    target_d    = target_q;
    bit_d       = bit_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = mid_q;
    mem_wdata_o = ones_q + add_bit;

    unique case (state_q)
      bvs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (bvs_pkg::func_e'(in_req_i.func))
            bvs_pkg::FUNC_APPEND: begin
              if (len_q < LEN_W'(MAX_BITS)) begin
                mem_we_o   = 1'b1;
                mem_addr_o = IDX_W'(len_q);
                len_d      = len_q + LEN_W'(1);
                ones_d     = ones_q + add_bit;
              end
            end
            bvs_pkg::FUNC_CLEAR: begin
              len_d  = '0;
              ones_d = '0;
            end
            bvs_pkg::FUNC_SELECT: begin
              bit_d = in_req_i.bit_value;
              if ((in_req_i.occurrence == '0) || (len_q == '0) ||
                  (TGT_W'(in_req_i.start_pos) > TGT_W'(len_q))) begin
                res_d   = '0;
                state_d = bvs_pkg::ST_DONE;
              end else if (in_req_i.start_pos >= bvs_pkg::POS_W'(2)) begin
                mid_d      = IDX_W'(start_idx);
                mem_addr_o = mid_d;
                target_d   = TGT_W'(in_req_i.occurrence);
                state_d    = bvs_pkg::ST_BASE;
              end else begin
                lo_d       = '0;
                hi_d       = len_q;
                mid_d      = IDX_W'(len_q >> 1);
                mem_addr_o = mid_d;
                target_d   = TGT_W'(in_req_i.occurrence);
                state_d    = bvs_pkg::ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bvs_pkg::ST_BASE: begin
        target_d   = TGT_W'(count_val) + target_q;
        lo_d       = '0;
        hi_d       = len_q;
        mid_d      = IDX_W'(len_q >> 1);
        mem_addr_o = mid_d;
        state_d    = bvs_pkg::ST_SEARCH;
      end
      bvs_pkg::ST_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d      = IDX_W'(mid_sum);
          mem_addr_o = mid_d;
        end else begin
          res_d.found    = lo_n < len_q;
          res_d.position = (lo_n < len_q) ? bvs_pkg::POS_W'(pos_sum) : '0;
          state_d        = bvs_pkg::ST_DONE;
        end
      end
      bvs_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = bvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bvs_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

// File: sv/bitvector_select_from_position.sv
// ----------------------------------------------------------------------------
// Bit-vector select from a position
// Stored bit vector with prefix counts and a select-from-position query.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (valid/ready). An append request stores one
// bit and a clear request empties the vector; neither gives a response. A select
// request returns one response on the out channel with the position of the
// wanted occurrence of the bit at or after the start position. A select is
// accepted, does a base read when the start lies past the first bit, runs the
// binary search (floor(log2(L))+1 steps for L loaded bits, 13 at 4096) and then
// hands the response to the output register. The single port of the prefix-count
// RAM is read once per search step. Requests that fail early checks skip the base
// read and the search.
// Reset empties the vector; the RAM is not cleared, since only written entries
// are ever read. A stalled receiver holds the output register; the block then
// finishes at most one more select and waits before taking further requests.
// ----------------------------------------------------------------------------
module bitvector_select_from_position #(
  parameter int unsigned MAX_BITS = bvs_pkg::MAX_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bvs_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bvs_pkg::out_req_t out_req_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BITS);
  localparam int unsigned LEN_W = $clog2(MAX_BITS + 1);

  logic              res_valid;
  logic              res_ready;
  bvs_pkg::out_req_t res;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [LEN_W-1:0]  mem_wdata;
  logic [LEN_W-1:0]  mem_rdata;

  logic              out_valid_q, out_valid_d;
  bvs_pkg::out_req_t out_req_q, out_req_d;

  bvs_engine #(
    .MAX_BITS(MAX_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  bvs_ram #(
    .WIDTH(LEN_W),
    .DEPTH(MAX_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_req_d   = out_req_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_req_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

`ifndef ASSERT_OFF
  a_ready_excl_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && res_valid))
    else $error("Engine takes requests while a response is pending.");

  a_select_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_req_i.func == bvs_pkg::FUNC_SELECT)) |=> !in_ready_o)
    else $error("Engine is ready right after accepting a select request.");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.found) |-> (out_req_o.position == '0))
    else $error("Response without a match carries a nonzero position.");

  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.found) |-> (res.position != '0))
    else $error("Matching response carries position zero.");
`endif

endmodule
